[sv/dijkstra_shortest_paths_unit_assert.svh]
// Assertion macros for the shortest path unit.
`ifndef DIJKSTRA_SHORTEST_PATHS_UNIT_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dijkstra_shortest_paths_unit: check failed");

`define DSP_ASSERT_IMPLY(name, ante, cons) \
  `DSP_ASSERT(name, (ante) |-> (cons))

`define DSP_ASSERT_NEXT(name, ante, cons) \
  `DSP_ASSERT(name, (ante) |=> (cons))

`else

`define DSP_ASSERT(name, prop)
`define DSP_ASSERT_IMPLY(name, ante, cons)
`define DSP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[sv/dsp_pkg.sv]
// Constants and types shared by the shortest path unit.
`default_nettype none

package dsp_pkg;

  localparam int unsigned MAX_VERTICES = 32;
  localparam int unsigned WEIGHT_BITS  = 16;

  localparam int unsigned VIDX_BITS  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EDGE_DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned EADDR_BITS = $clog2(EDGE_DEPTH);

  localparam int unsigned VERTEX_BITS = 5;
  localparam int unsigned COUNT_BITS  = 6;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned DIST_BITS   = 21;
  localparam logic [DIST_BITS-1:0] LEN_MAX = '1;
  localparam int unsigned SUM_BITS =
    ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

  typedef struct packed {
    logic                   valid;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_entry_t;

  typedef struct packed {
    logic                 settled;
    logic                 reached;
    logic [DIST_BITS-1:0] plen;
  } dist_entry_t;

  localparam int unsigned EDGE_W = $bits(edge_entry_t);
  localparam int unsigned DIST_W = $bits(dist_entry_t);

  function automatic logic [EADDR_BITS-1:0] edge_addr(input logic [VIDX_BITS-1:0] from_v,
                                                      input logic [VIDX_BITS-1:0] to_v);
    return EADDR_BITS'(EADDR_BITS'(from_v) * EADDR_BITS'(MAX_VERTICES)) + EADDR_BITS'(to_v);
  endfunction

endpackage

`default_nettype wire

[sv/dsp_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module dsp_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sv/dijkstra_shortest_paths_unit.sv]
// Top level of the single-source shortest path unit: sequencer and memories.
`default_nettype none

// After reset the edge store is cleared one entry per cycle, which keeps busy
// high until every entry is cleared. An edge beat does a read and a write-back
// for each direction. A run beat first initializes every entry of the distance
// memory, then makes a pass for every vertex that gets settled, each pass
// streaming one adjacency row through the edge memory read port, and then
// streams out one result for each vertex in use.
// Results come out on consecutive cycles, in vertex order, one per valid_o
// strobe; the receiver cannot stall them and must take each one when it shows.
module dijkstra_shortest_paths_unit
  import dsp_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   kind_i,
  input  wire logic [VERTEX_BITS-1:0] end_a_i,
  input  wire logic [VERTEX_BITS-1:0] end_b_i,
  input  wire logic [FIELD_BITS-1:0]  edge_weight_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [COUNT_BITS-1:0]  cfg_data_i,
  output logic                        valid_o,
  output logic [VERTEX_BITS-1:0]      vertex_o,
  output logic [DIST_BITS-1:0]        path_length_o,
  output logic                        reachable_o,
  output logic                        last_o
);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_ADD_RD1   = 4'd2;
  localparam logic [3:0] ST_ADD_WR1   = 4'd3;
  localparam logic [3:0] ST_ADD_RD2   = 4'd4;
  localparam logic [3:0] ST_ADD_WR2   = 4'd5;
  localparam logic [3:0] ST_INIT      = 4'd6;
  localparam logic [3:0] ST_SETTLE    = 4'd7;
  localparam logic [3:0] ST_RELAX     = 4'd8;
  localparam logic [3:0] ST_RELAX_END = 4'd9;
  localparam logic [3:0] ST_OUT       = 4'd10;
  localparam logic [3:0] ST_OUT_END   = 4'd11;

  localparam logic [VIDX_BITS-1:0]  LAST_VIDX = VIDX_BITS'(MAX_VERTICES - 1);
  localparam logic [EADDR_BITS-1:0] LAST_EADDR = EADDR_BITS'(EDGE_DEPTH - 1);

  logic [3:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] count_q;
  logic [EADDR_BITS-1:0] clr_q, clr_d;
  logic                  pend_q, pend_d;
  logic                  found_q, found_d;
  logic                  valid_q, valid_d;

  logic                   kind_q, kind_d;
  logic [VERTEX_BITS-1:0] a_q, a_d;
  logic [VERTEX_BITS-1:0] b_q, b_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic                   edge_ok_q, edge_ok_d;
  logic [VIDX_BITS-1:0]   nm1_q, nm1_d;
  logic [VIDX_BITS-1:0]   ri_q, ri_d;
  logic [VIDX_BITS-1:0]   pidx_q, pidx_d;
  logic [VIDX_BITS-1:0]   u_q, u_d;
  logic [DIST_BITS-1:0]   du_q, du_d;
  logic [VIDX_BITS-1:0]   bestu_q, bestu_d;
  logic [DIST_BITS-1:0]   bestd_q, bestd_d;
  logic [VERTEX_BITS-1:0] vertex_q, vertex_d;
  logic [DIST_BITS-1:0]   len_q, len_d;
  logic                   reach_q, reach_d;
  logic                   last_q, last_d;

  logic                  e_we;
  logic [EADDR_BITS-1:0] e_waddr, e_raddr;
  edge_entry_t           e_wdata, e_rdata;
  logic                  d_we;
  logic [VIDX_BITS-1:0]  d_waddr;
  dist_entry_t           d_wdata, d_rdata;

  logic [SUM_BITS-1:0]  sum;
  logic [DIST_BITS-1:0] dnew, post_d;
  logic                 upd, post_r, relax_act, cand;
  logic [EADDR_BITS-1:0] addr_ab, addr_ba;
  logic [VIDX_BITS-1:0]  nm1_new;

  dsp_ram #(
    .DEPTH(EDGE_DEPTH),
    .WIDTH(EDGE_W)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  dsp_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(DIST_W)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .raddr_i(ri_q),
    .rdata_o(d_rdata)
  );

  assign addr_ab = edge_addr(VIDX_BITS'(a_q), VIDX_BITS'(b_q));
  assign addr_ba = edge_addr(VIDX_BITS'(b_q), VIDX_BITS'(a_q));

  always_comb begin
    if (count_q == '0) begin
      nm1_new = '0;
    end else if (int'(count_q) > MAX_VERTICES) begin
      nm1_new = LAST_VIDX;
    end else begin
      nm1_new = VIDX_BITS'(count_q - 1'b1);
    end
  end

  // Relaxation of the entry read in the previous cycle, with the running minimum
  // over the unsettled reached vertices that picks the next vertex to settle.
  always_comb begin
    sum    = SUM_BITS'(du_q) + SUM_BITS'(e_rdata.weight);
    dnew   = (sum > SUM_BITS'(LEN_MAX)) ? LEN_MAX : DIST_BITS'(sum);
    upd    = e_rdata.valid && !d_rdata.settled && (!d_rdata.reached || dnew < d_rdata.plen);
    post_r = d_rdata.reached || upd;
    post_d = upd ? dnew : d_rdata.plen;
    relax_act = pend_q && ((state_q == ST_RELAX) || (state_q == ST_RELAX_END));
    cand = relax_act && post_r && !d_rdata.settled && (!found_q || post_d < bestd_q);
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pend_d    = 1'b0;
    found_d   = found_q || cand;
    bestu_d   = cand ? pidx_q : bestu_q;
    bestd_d   = cand ? post_d : bestd_q;
    valid_d   = 1'b0;
    kind_d    = kind_q;
    a_d       = a_q;
    b_d       = b_q;
    w_d       = w_q;
    edge_ok_d = edge_ok_q;
    nm1_d     = nm1_q;
    ri_d      = ri_q;
    pidx_d    = pidx_q;
    u_d       = u_q;
    du_d      = du_q;
    vertex_d  = vertex_q;
    len_d     = len_q;
    reach_d   = reach_q;
    last_d    = last_q;

    e_we    = 1'b0;
    e_waddr = addr_ab;
    e_wdata = '{valid: 1'b1, weight: w_q};
    e_raddr = edge_addr(u_q, ri_q);
    d_we    = 1'b0;
    d_waddr = pidx_q;
    d_wdata = '{settled: 1'b0, reached: 1'b1, plen: dnew};

    if (pend_q && ((state_q == ST_OUT) || (state_q == ST_OUT_END))) begin
      valid_d  = 1'b1;
      vertex_d = VERTEX_BITS'(pidx_q);
      len_d    = d_rdata.reached ? d_rdata.plen : '0;
      reach_d  = d_rdata.reached;
      last_d   = (pidx_q == nm1_q);
    end

    unique case (state_q)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_q;
        e_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_EADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          kind_d    = kind_i;
          a_d       = end_a_i;
          b_d       = end_b_i;
          w_d       = WEIGHT_BITS'(edge_weight_i);
          edge_ok_d = (int'(end_a_i) < MAX_VERTICES) && (int'(end_b_i) < MAX_VERTICES);
          nm1_d     = nm1_new;
          ri_d      = '0;
          state_d   = kind_i ? ST_INIT : ST_ADD_RD1;
        end
      end
      ST_ADD_RD1: begin
        e_raddr = addr_ab;
        state_d = ST_ADD_WR1;
      end
      ST_ADD_WR1: begin
        e_waddr = addr_ab;
        e_we    = edge_ok_q && (!e_rdata.valid || w_q < e_rdata.weight);
        state_d = ST_ADD_RD2;
      end
      ST_ADD_RD2: begin
        e_raddr = addr_ba;
        state_d = ST_ADD_WR2;
      end
      ST_ADD_WR2: begin
        e_waddr = addr_ba;
        e_we    = edge_ok_q && (!e_rdata.valid || w_q < e_rdata.weight);
        state_d = ST_IDLE;
      end
      ST_INIT: begin
        d_we    = 1'b1;
        d_waddr = ri_q;
        d_wdata = '0;
        ri_d    = ri_q + 1'b1;
        if (ri_q == LAST_VIDX) begin
          ri_d = '0;
          if (int'(a_q) <= int'(nm1_q)) begin
            u_d     = VIDX_BITS'(a_q);
            du_d    = '0;
            state_d = ST_SETTLE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SETTLE: begin
        d_we    = 1'b1;
        d_waddr = u_q;
        d_wdata = '{settled: 1'b1, reached: 1'b1, plen: du_q};
        ri_d    = '0;
        found_d = 1'b0;
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        d_we   = relax_act && upd;
        pend_d = 1'b1;
        pidx_d = ri_q;
        ri_d   = ri_q + 1'b1;
        if (ri_q == nm1_q) begin
          state_d = ST_RELAX_END;
        end
      end
      ST_RELAX_END: begin
        d_we = relax_act && upd;
        ri_d = '0;
        if (found_d) begin
          u_d     = bestu_d;
          du_d    = bestd_d;
          state_d = ST_SETTLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        pend_d = 1'b1;
        pidx_d = ri_q;
        ri_d   = ri_q + 1'b1;
        if (ri_q == nm1_q) begin
          state_d = ST_OUT_END;
        end
      end
      ST_OUT_END: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      count_q <= COUNT_BITS'(32);
      clr_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    a_q       <= a_d;
    b_q       <= b_d;
    w_q       <= w_d;
    edge_ok_q <= edge_ok_d;
    nm1_q     <= nm1_d;
    ri_q      <= ri_d;
    pidx_q    <= pidx_d;
    u_q       <= u_d;
    du_q      <= du_d;
    bestu_q   <= bestu_d;
    bestd_q   <= bestd_d;
    vertex_q  <= vertex_d;
    len_q     <= len_d;
    reach_q   <= reach_d;
    last_q    <= last_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign vertex_o      = vertex_q;
  assign path_length_o = len_q;
  assign reachable_o   = reach_q;
  assign last_o        = last_q;

  `include "dijkstra_shortest_paths_unit_assert.svh"

  `DSP_ASSERT_NEXT(a_beat_holds_busy, start && !busy, busy)
  `DSP_ASSERT_NEXT(a_results_in_order, valid_o && !last_o, valid_o && (vertex_o == $past(vertex_o) + 1'b1))
  `DSP_ASSERT_IMPLY(a_no_result_in_clear, state_q == ST_CLEAR, !valid_o)
  `DSP_ASSERT_IMPLY(a_unreached_zero, valid_o && !reachable_o, path_length_o == '0)
  `DSP_ASSERT_IMPLY(a_settle_only_in_run, state_q == ST_SETTLE, kind_q && (int'(u_q) <= int'(nm1_q)))

endmodule

`default_nettype wire

[verif/tb_dijkstra_shortest_paths_unit.sv]
// Self-checking testbench for the shortest path unit: edge loads feed the model, runs are checked per vertex.
module tb_dijkstra_shortest_paths_unit;
  import dsp_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned ITEM_GOAL   = 430;
  localparam int unsigned SETTLE_WAIT = 8;
  localparam int unsigned TAIL_WAIT   = 64;
  localparam int unsigned SLOTS       = MAX_VERTICES * MAX_VERTICES;
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef enum logic [1:0] {ROW_EDGE, ROW_RUN, ROW_COUNT} row_op_e;
  typedef enum logic [1:0] {WANT_MODEL, WANT_ALONE, WANT_NONE} want_e;

  typedef struct packed {
    row_op_e                op;
    logic [VERTEX_BITS-1:0] a;
    logic [VERTEX_BITS-1:0] b;
    logic [FIELD_BITS-1:0]  w;
    want_e                  want;
  } row_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex;
    logic [DIST_BITS-1:0]   span;
    logic                   reach;
    logic                   last;
  } path_beat_t;

  localparam int unsigned SCRIPT_LEN = 29;
  localparam row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{ROW_RUN,   5'd0,  5'd0,  16'd0,      WANT_ALONE},
    '{ROW_RUN,   5'd31, 5'd0,  16'd0,      WANT_ALONE},
    '{ROW_EDGE,  5'd0,  5'd1,  16'd0,      WANT_MODEL},
    '{ROW_EDGE,  5'd1,  5'd2,  16'hFFFF,   WANT_MODEL},
    '{ROW_EDGE,  5'd2,  5'd2,  16'd5,      WANT_MODEL},
    '{ROW_EDGE,  5'd1,  5'd0,  16'd7,      WANT_MODEL},
    '{ROW_EDGE,  5'd2,  5'd31, 16'hFFFF,   WANT_MODEL},
    '{ROW_EDGE,  5'd31, 5'd30, 16'hAAAA,   WANT_MODEL},
    '{ROW_RUN,   5'd0,  5'd0,  16'd0,      WANT_MODEL},
    '{ROW_EDGE,  5'd2,  5'd1,  16'd3,      WANT_MODEL},
    '{ROW_RUN,   5'd2,  5'd0,  16'd0,      WANT_MODEL},
    '{ROW_COUNT, 5'd0,  5'd0,  16'd1,      WANT_MODEL},
    '{ROW_RUN,   5'd0,  5'd0,  16'd0,      WANT_ALONE},
    '{ROW_RUN,   5'd5,  5'd0,  16'd0,      WANT_NONE},
    '{ROW_COUNT, 5'd0,  5'd0,  16'd0,      WANT_MODEL},
    '{ROW_RUN,   5'd0,  5'd0,  16'd0,      WANT_ALONE},
    '{ROW_RUN,   5'd31, 5'd0,  16'd0,      WANT_NONE},
    '{ROW_COUNT, 5'd0,  5'd0,  16'd63,     WANT_MODEL},
    '{ROW_RUN,   5'd31, 5'd0,  16'd0,      WANT_MODEL},
    '{ROW_COUNT, 5'd0,  5'd0,  16'd5,      WANT_MODEL},
    '{ROW_EDGE,  5'd3,  5'd4,  16'h5555,   WANT_MODEL},
    '{ROW_EDGE,  5'd4,  5'd20, 16'd1,      WANT_MODEL},
    '{ROW_EDGE,  5'd3,  5'd0,  16'h0F0F,   WANT_MODEL},
    '{ROW_RUN,   5'd4,  5'd0,  16'd0,      WANT_MODEL},
    '{ROW_RUN,   5'd3,  5'd0,  16'd0,      WANT_MODEL},
    '{ROW_COUNT, 5'd0,  5'd0,  16'd32,     WANT_MODEL},
    '{ROW_RUN,   5'd30, 5'd0,  16'd0,      WANT_MODEL},
    '{ROW_EDGE,  5'd29, 5'd28, 16'h8000,   WANT_MODEL},
    '{ROW_RUN,   5'd28, 5'd0,  16'd0,      WANT_MODEL}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   kind_i;
  logic [VERTEX_BITS-1:0] end_a_i;
  logic [VERTEX_BITS-1:0] end_b_i;
  logic [FIELD_BITS-1:0]  edge_weight_i;
  logic                   cfg_we_i;
  logic [COUNT_BITS-1:0]  cfg_data_i;
  logic                   valid_o;
  logic [VERTEX_BITS-1:0] vertex_o;
  logic [DIST_BITS-1:0]   path_length_o;
  logic                   reachable_o;
  logic                   last_o;

  bit                     link_set [SLOTS];
  logic [WEIGHT_BITS-1:0] link_len [SLOTS];
  logic [COUNT_BITS-1:0]  count_cfg;
  path_beat_t             path_beats_due [$];
  int unsigned            mismatches;
  int unsigned            beats_in;
  int unsigned            quiet;

  dijkstra_shortest_paths_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .end_a_i       (end_a_i),
    .end_b_i       (end_b_i),
    .edge_weight_i (edge_weight_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .vertex_o      (vertex_o),
    .path_length_o (path_length_o),
    .reachable_o   (reachable_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int active_count();
    if (count_cfg == 0) return 1;
    if (count_cfg > MAX_VERTICES) return int'(MAX_VERTICES);
    return int'(count_cfg);
  endfunction

  function automatic void note_link(int x, int y, logic [WEIGHT_BITS-1:0] w);
    int slot;
    slot = x * MAX_VERTICES + y;
    if (!link_set[slot] || w < link_len[slot]) begin
      link_set[slot] = 1'b1;
      link_len[slot] = w;
    end
  endfunction

  function automatic void shortest_paths_from(int src);
    longint unsigned span [MAX_VERTICES];
    bit              seen [MAX_VERTICES];
    bit              done [MAX_VERTICES];
    longint unsigned trial;
    path_beat_t      beat;
    int              n, u, slot, i, k;
    n = active_count();
    for (i = 0; i < MAX_VERTICES; i++) begin
      span[i] = 0;
      seen[i] = 1'b0;
      done[i] = 1'b0;
    end
    if (src < n) seen[src] = 1'b1;
    for (k = 0; k < n; k++) begin
      u = n;
      for (i = 0; i < n; i++) begin
        if (seen[i] && !done[i] && (u == n || span[i] < span[u])) u = i;
      end
      if (u == n) break;
      done[u] = 1'b1;
      for (i = 0; i < n; i++) begin
        slot = u * MAX_VERTICES + i;
        if (link_set[slot] && !done[i]) begin
          trial = span[u] + longint'(link_len[slot]);
          if (!seen[i] || trial < span[i]) begin
            span[i] = trial;
            seen[i] = 1'b1;
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      beat.vertex = VERTEX_BITS'(i);
      beat.reach  = seen[i];
      beat.last   = (i == n - 1);
      if (!seen[i]) beat.span = '0;
      else if (span[i] > longint'(LEN_MAX)) beat.span = LEN_MAX;
      else beat.span = span[i][DIST_BITS-1:0];
      path_beats_due = {path_beats_due, beat};
    end
  endfunction

  // A run over a graph with no usable edge: only the start, if src_reached is set, is reached at zero.
  function automatic void isolated_paths(int src, bit src_reached);
    path_beat_t beat;
    int         n, i;
    n = active_count();
    for (i = 0; i < n; i++) begin
      beat.vertex = VERTEX_BITS'(i);
      beat.span   = '0;
      beat.reach  = src_reached && (i == src);
      beat.last   = (i == n - 1);
      path_beats_due = {path_beats_due, beat};
    end
  endfunction

  task automatic put_beat(input logic kind, input logic [VERTEX_BITS-1:0] a,
                          input logic [VERTEX_BITS-1:0] b, input logic [FIELD_BITS-1:0] w,
                          input want_e want, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start         = 1'b0;
      kind_i        = 1'($urandom);
      end_a_i       = VERTEX_BITS'($urandom);
      end_b_i       = VERTEX_BITS'($urandom);
      edge_weight_i = FIELD_BITS'($urandom);
    end
    @(negedge clk_i);
    start         = 1'b1;
    kind_i        = kind;
    end_a_i       = a;
    end_b_i       = b;
    edge_weight_i = w;
    do @(posedge clk_i); while (busy);
    beats_in++;
    if (kind == KIND_EDGE) begin
      note_link(int'(a), int'(b), w[WEIGHT_BITS-1:0]);
      note_link(int'(b), int'(a), w[WEIGHT_BITS-1:0]);
    end else if (want == WANT_MODEL) begin
      shortest_paths_from(int'(a));
    end else begin
      isolated_paths(int'(a), want == WANT_ALONE);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (path_beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_count(input logic [COUNT_BITS-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    @(posedge clk_i);
    count_cfg = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_data_i = COUNT_BITS'($urandom);
  endtask

  task automatic report_bad(input string what, input int want_v, input int got_v);
    mismatches++;
    $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk_i) begin
    path_beat_t due;
    if (rst_ni && valid_o) begin
      if (path_beats_due.size() == 0) begin
        report_bad("unexpected beat, vertex", -1, int'(vertex_o));
      end else begin
        due = path_beats_due.pop_front();
        if (vertex_o !== due.vertex)
          report_bad("vertex", int'(due.vertex), int'(vertex_o));
        if (path_length_o !== due.span)
          report_bad("path_length", int'(due.span), int'(path_length_o));
        if (reachable_o !== due.reach)
          report_bad("reachable", int'(due.reach), int'(reachable_o));
        if (last_o !== due.last) report_bad("last", int'(due.last), int'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("tb_dijkstra_shortest_paths_unit: errors");
      $finish;
    end
  end

  initial begin
    int                     r, phase, idle_pct, n, count_roll, edge_cnt, run_cnt, j;
    logic [COUNT_BITS-1:0]  next_count;
    logic [VERTEX_BITS-1:0] pa, pb;
    logic [FIELD_BITS-1:0]  pw;
    rst_ni        = 1'b0;
    start         = 1'b0;
    kind_i        = 1'b0;
    end_a_i       = '0;
    end_b_i       = '0;
    edge_weight_i = '0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    count_cfg     = COUNT_BITS'(MAX_VERTICES);
    mismatches    = 0;
    beats_in      = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (r = 0; r < SCRIPT_LEN; r++) begin
      case (SCRIPT[r].op)
        ROW_COUNT: begin
          set_count(SCRIPT[r].w[COUNT_BITS-1:0]);
        end
        ROW_EDGE: begin
          put_beat(KIND_EDGE, SCRIPT[r].a, SCRIPT[r].b, SCRIPT[r].w, WANT_MODEL, 0);
        end
        default: begin
          put_beat(KIND_RUN, SCRIPT[r].a, SCRIPT[r].b, SCRIPT[r].w, SCRIPT[r].want, 0);
        end
      endcase
    end

    phase = 0;
    while (beats_in < ITEM_GOAL) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 53;
        default: idle_pct = 15;
      endcase
      count_roll = $urandom_range(0, 9);
      if (count_roll < 6) next_count = COUNT_BITS'($urandom_range(2, 8));
      else if (count_roll == 6) next_count = COUNT_BITS'($urandom_range(9, 31));
      else if (count_roll == 7) next_count = COUNT_BITS'(MAX_VERTICES);
      else if (count_roll == 8) next_count = COUNT_BITS'($urandom_range(0, 1));
      else next_count = COUNT_BITS'($urandom_range(MAX_VERTICES + 1, 63));
      set_count(next_count);
      n = active_count();

      edge_cnt = $urandom_range(2, 12);
      for (j = 0; j < edge_cnt; j++) begin
        if ($urandom_range(0, 4) != 0) begin
          pa = VERTEX_BITS'($urandom_range(0, n - 1));
          pb = VERTEX_BITS'($urandom_range(0, n - 1));
        end else begin
          pa = VERTEX_BITS'($urandom);
          pb = VERTEX_BITS'($urandom);
        end
        case ($urandom_range(0, 3))
          0: pw = FIELD_BITS'($urandom);
          1: pw = FIELD_BITS'($urandom_range(0, 15));
          2: pw = $urandom_range(0, 1) ? '1 : '0;
          default: pw = FIELD_BITS'($urandom_range(0, 1023));
        endcase
        put_beat(KIND_EDGE, pa, pb, pw, WANT_MODEL, idle_pct);
      end

      if ($urandom_range(0, 3) == 0) drain();

      run_cnt = $urandom_range(1, 3);
      for (j = 0; j < run_cnt; j++) begin
        if ($urandom_range(0, 9) != 0) pa = VERTEX_BITS'($urandom_range(0, n - 1));
        else pa = VERTEX_BITS'($urandom);
        put_beat(KIND_RUN, pa, VERTEX_BITS'($urandom), FIELD_BITS'($urandom),
                 WANT_MODEL, idle_pct);
      end
      phase++;
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && path_beats_due.size() == 0) begin
      $display("tb_dijkstra_shortest_paths_unit: clean");
    end else begin
      $display("tb_dijkstra_shortest_paths_unit: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/dsp_pkg.sv
sv/dsp_ram.sv
sv/dijkstra_shortest_paths_unit.sv
verif/tb_dijkstra_shortest_paths_unit.sv
